// ===== hw/rtl/xild_pkg.sv =====
// types, constants and opcode class tables for the x86-64 length decoder
// no dependencies; used by the top level and the testbench
`timescale 1ns / 1ps
`default_nettype none

package xild_pkg;

  localparam logic [7:0] BYTE_OPSIZE  = 8'h66;
  localparam logic [7:0] BYTE_ESCAPE  = 8'h0F;
  localparam logic [7:0] BYTE_MAP38   = 8'h38;
  localparam logic [7:0] BYTE_MAP3A   = 8'h3A;
  localparam logic [7:0] REX_MASK     = 8'hF0;
  localparam logic [7:0] REX_BASE     = 8'h40;
  localparam logic [7:0] REX_W_BIT    = 8'h08;

  localparam logic [1:0] MOD_DISP0    = 2'd0;
  localparam logic [1:0] MOD_DISP8    = 2'd1;
  localparam logic [1:0] MOD_DISP32   = 2'd2;
  localparam logic [1:0] MOD_REG      = 2'd3;
  localparam logic [2:0] RM_SIB       = 3'd4;
  localparam logic [2:0] RM_DISP32    = 3'd5;

  typedef enum logic [2:0] {
    PH_PREFIX = 3'd0,
    PH_OPCODE = 3'd1,
    PH_ESCAPE = 3'd2,
    PH_MAP3   = 3'd3,
    PH_MODRM  = 3'd4,
    PH_SIB    = 3'd5,
    PH_SKIP   = 3'd6
  } phase_e;

  typedef enum logic [3:0] {
    K_INVALID = 4'd0,
    K_NONE    = 4'd1,
    K_M       = 4'd2,
    K_M_I8    = 4'd3,
    K_M_IZ    = 4'd4,
    K_I8      = 4'd5,
    K_IZ      = 4'd6,
    K_I16     = 4'd7,
    K_REL8    = 4'd8,
    K_REL32   = 4'd9,
    K_MOVI    = 4'd10,
    K_GF6     = 4'd11,
    K_GF7     = 4'd12
  } op_class_e;

  typedef enum logic [1:0] {
    ST_DECODED = 2'd0,
    ST_INVALID = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OC_PENDING = 2'd0,
    OC_DONE    = 2'd1,
    OC_BAD     = 2'd2
  } outcome_e;

  typedef struct packed {
    phase_e      phase;
    logic [4:0]  bytes_taken;
    logic        operand_size_short;
    logic        rex_wide;
    op_class_e   opcode_class;
    logic [1:0]  saved_mod;
    logic [3:0]  bytes_to_skip;
    logic [3:0]  pending_immediate;
    logic        rip_flag;
    logic [3:0]  disp_position;
  } dec_state_t;

  function automatic logic is_legacy_prefix(input logic [7:0] b);
    return b == 8'h67 || b == 8'hF0 || b == 8'hF2 || b == 8'hF3 ||
           b == 8'h2E || b == 8'h36 || b == 8'h3E || b == 8'h26 ||
           b == 8'h64 || b == 8'h65;
  endfunction

  function automatic op_class_e primary_class(input logic [7:0] b);
    op_class_e k;
    k = K_INVALID;
    priority if (b < 8'h40) begin
      if (b == BYTE_ESCAPE) k = K_INVALID;
      else if (b[2:0] <= 3'd3) k = K_M;
      else if (b[2:0] == 3'd4) k = K_I8;
      else if (b[2:0] == 3'd5) k = K_IZ;
      else k = K_INVALID;
    end else if (b >= 8'h50 && b <= 8'h5F) begin
      k = K_NONE;
    end else if (b >= 8'h70 && b <= 8'h7F) begin
      k = K_REL8;
    end else if (b >= 8'h84 && b <= 8'h8B) begin
      k = K_M;
    end else if (b >= 8'h90 && b <= 8'h99) begin
      k = K_NONE;
    end else if (b >= 8'hB0 && b <= 8'hB7) begin
      k = K_I8;
    end else if (b >= 8'hB8 && b <= 8'hBF) begin
      k = K_MOVI;
    end else if (b >= 8'hD0 && b <= 8'hD3) begin
      k = K_M;
    end else begin
      case (b)
        8'h63, 8'h8D, 8'h8F, 8'hFE, 8'hFF:               k = K_M;
        8'h68, 8'hA9:                                    k = K_IZ;
        8'h69, 8'h81, 8'hC7:                             k = K_M_IZ;
        8'h6A, 8'hA8:                                    k = K_I8;
        8'h6B, 8'h80, 8'h83, 8'hC0, 8'hC1, 8'hC6:        k = K_M_I8;
        8'h9C, 8'h9D, 8'hC3, 8'hC9, 8'hCC, 8'hF4:        k = K_NONE;
        8'hC2:                                           k = K_I16;
        8'hE8, 8'hE9:                                    k = K_REL32;
        8'hEB:                                           k = K_REL8;
        8'hF6:                                           k = K_GF6;
        8'hF7:                                           k = K_GF7;
        default:                                         k = K_INVALID;
      endcase
    end
    return k;
  endfunction

  function automatic op_class_e secondary_class(input logic [7:0] b);
    op_class_e k;
    k = K_INVALID;
    priority if ((b >= 8'h10 && b <= 8'h1F) || (b >= 8'h28 && b <= 8'h2F) ||
                 (b >= 8'h40 && b <= 8'h4F) || (b >= 8'h51 && b <= 8'h6F) ||
                 (b >= 8'h74 && b <= 8'h7F) || (b >= 8'h90 && b <= 8'h9F) ||
                 (b >= 8'hB3 && b <= 8'hB7) || (b >= 8'hBB && b <= 8'hBF) ||
                 (b >= 8'hC3 && b <= 8'hC6) || (b >= 8'hD0 && b <= 8'hFE)) begin
      k = K_M;
    end else if (b >= 8'h70 && b <= 8'h73) begin
      k = K_M_I8;
    end else if (b >= 8'h80 && b <= 8'h8F) begin
      k = K_REL32;
    end else begin
      case (b)
        8'h05, 8'h0B, 8'hA2:                             k = K_NONE;
        8'hA3, 8'hA5, 8'hAB, 8'hAD, 8'hAE, 8'hAF,
        8'hB0, 8'hB1, 8'hC0, 8'hC1:                      k = K_M;
        8'hA4, 8'hAC, 8'hBA, 8'hC2:                      k = K_M_I8;
        default:                                         k = K_INVALID;
      endcase
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/xild_in_if.sv =====
// input channel of the length decoder: one code byte per beat
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface xild_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       start_req;

  modport source (output valid, output code_byte, output start_req, input ready);
  modport sink   (input valid, input code_byte, input start_req, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/xild_out_if.sv =====
// result channel of the length decoder: one measured instruction per beat
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface xild_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] length;
  logic       relative_branch;
  logic       rip_relative;
  logic [3:0] displacement_offset;
  logic [3:0] immediate_size;

  modport source (output valid, output status, output length, output relative_branch,
                  output rip_relative, output displacement_offset,
                  output immediate_size, input ready);
  modport sink   (input valid, input status, input length, input relative_branch,
                  input rip_relative, input displacement_offset,
                  input immediate_size, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/x86_64_instruction_length_decoder.sv =====
// byte-serial x86-64 instruction length decoder, top level
// depends on xild_pkg, xild_in_if and xild_out_if
//
//   channel  dir  beat                                 handshake
//   in_i     in   code_byte, start_req                 valid/ready
//   out_o    out  status, length, branch/rip flags,    valid/ready
//                 displacement offset, immediate size
//
// one code byte per cycle while in_i is ready; each byte steps the decode state through the
// opcode class tables and, on completion or failure, loads the result register
// a result is registered and appears in the cycle after the byte that ends the instruction
// in_i stays ready while the result register is empty or being drained
// reset clears the decode state to prefix scan and empties the result register
`timescale 1ns / 1ps
`default_nettype none

module x86_64_instruction_length_decoder
  import xild_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  xild_in_if.sink     in_i,
  xild_out_if.source  out_o
);

  dec_state_t state_q, state_d;
  dec_state_t cur, nxt;
  outcome_e   outcome;
  op_class_e  begin_cls;
  logic       do_begin;
  logic       do_tail;
  logic [3:0] tail_n;
  logic [3:0] imm;
  logic [3:0] disp;
  logic [3:0] immz;
  logic [7:0] b;
  logic       emit;
  logic       accept;

  logic       out_valid_q;
  logic [1:0] status_q, status_d;
  logic [4:0] length_q, length_d;
  logic       rel_q, rel_d;
  logic       rip_q, rip_d;
  logic [3:0] dpos_q, dpos_d;
  logic [3:0] imm_q, imm_d;

  assign b        = in_i.code_byte;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept   = in_i.valid && in_i.ready;

  always_comb begin
    cur       = in_i.start_req ? dec_state_t'('0) : state_q;
    nxt       = cur;
    nxt.bytes_taken = cur.bytes_taken + 5'd1;
    outcome   = OC_PENDING;
    do_begin  = 1'b0;
    begin_cls = K_INVALID;
    do_tail   = 1'b0;
    tail_n    = '0;
    imm       = '0;
    disp      = '0;
    immz      = cur.operand_size_short ? 4'd2 : 4'd4;

    unique case (cur.phase)
      PH_OPCODE: begin
        if (b == BYTE_ESCAPE) begin
          nxt.phase = PH_ESCAPE;
        end else begin
          do_begin  = 1'b1;
          begin_cls = primary_class(b);
        end
      end
      PH_ESCAPE: begin
        if (b == BYTE_MAP38 || b == BYTE_MAP3A) begin
          nxt.opcode_class = (b == BYTE_MAP3A) ? K_M_I8 : K_M;
          nxt.phase        = PH_MAP3;
        end else begin
          do_begin  = 1'b1;
          begin_cls = secondary_class(b);
        end
      end
      PH_MAP3: begin
        nxt.phase = PH_MODRM;
      end
      PH_MODRM: begin
        unique case (cur.opcode_class)
          K_GF6:   imm = (b[5:4] == 2'd0) ? 4'd1 : 4'd0;
          K_GF7:   imm = (b[5:4] == 2'd0) ? immz : 4'd0;
          K_M_I8:  imm = 4'd1;
          K_M_IZ:  imm = immz;
          default: imm = 4'd0;
        endcase
        nxt.pending_immediate = imm;
        if (b[7:6] != MOD_REG && b[2:0] == RM_SIB) begin
          nxt.saved_mod = b[7:6];
          nxt.phase     = PH_SIB;
        end else begin
          if (b[7:6] == MOD_DISP8) begin
            disp = 4'd1;
          end else if (b[7:6] == MOD_DISP32) begin
            disp = 4'd4;
          end else if (b[7:6] == MOD_DISP0 && b[2:0] == RM_DISP32) begin
            nxt.rip_flag      = 1'b1;
            nxt.disp_position = nxt.bytes_taken[3:0];
            disp              = 4'd4;
          end
          do_tail = 1'b1;
          tail_n  = disp + imm;
        end
      end
      PH_SIB: begin
        if (cur.saved_mod == MOD_DISP8) disp = 4'd1;
        else if (cur.saved_mod == MOD_DISP32) disp = 4'd4;
        else if (cur.saved_mod == MOD_DISP0 && b[2:0] == RM_DISP32) disp = 4'd4;
        do_tail = 1'b1;
        tail_n  = disp + cur.pending_immediate;
      end
      PH_SKIP: begin
        nxt.bytes_to_skip = cur.bytes_to_skip - 4'd1;
        if (nxt.bytes_to_skip == 4'd0) outcome = OC_DONE;
      end
      default: begin
        if (b == BYTE_OPSIZE) begin
          nxt.operand_size_short = 1'b1;
        end else if (is_legacy_prefix(b)) begin
          nxt.phase = cur.phase;
        end else if ((b & REX_MASK) == REX_BASE) begin
          nxt.rex_wide = (b & REX_W_BIT) != 8'd0;
          nxt.phase    = PH_OPCODE;
        end else if (b == BYTE_ESCAPE) begin
          nxt.phase = PH_ESCAPE;
        end else begin
          do_begin  = 1'b1;
          begin_cls = primary_class(b);
        end
      end
    endcase

    if (do_begin) begin
      nxt.opcode_class = begin_cls;
      unique case (begin_cls)
        K_NONE: begin
          nxt.pending_immediate = '0;
          outcome = OC_DONE;
        end
        K_REL8: begin
          nxt.pending_immediate = '0;
          do_tail = 1'b1;
          tail_n  = 4'd1;
        end
        K_REL32: begin
          nxt.pending_immediate = '0;
          do_tail = 1'b1;
          tail_n  = 4'd4;
        end
        K_M, K_M_I8, K_M_IZ, K_GF6, K_GF7: begin
          nxt.phase = PH_MODRM;
        end
        K_I8, K_I16, K_IZ, K_MOVI: begin
          unique case (begin_cls)
            K_I8:    imm = 4'd1;
            K_I16:   imm = 4'd2;
            K_IZ:    imm = immz;
            default: imm = cur.rex_wide ? 4'd8 : immz;
          endcase
          nxt.pending_immediate = imm;
          do_tail = 1'b1;
          tail_n  = imm;
        end
        default: begin
          outcome = OC_BAD;
        end
      endcase
    end

    if (do_tail) begin
      if (tail_n == 4'd0) begin
        outcome = OC_DONE;
      end else begin
        nxt.bytes_to_skip = tail_n;
        nxt.phase         = PH_SKIP;
      end
    end

    emit = (outcome != OC_PENDING) || (nxt.bytes_taken >= 5'(MAX_LENGTH));

    status_d = ST_TOO_LONG;
    length_d = '0;
    rel_d    = 1'b0;
    rip_d    = 1'b0;
    dpos_d   = '0;
    imm_d    = '0;
    if (outcome == OC_BAD) begin
      status_d = ST_INVALID;
    end else if (outcome == OC_DONE && nxt.bytes_taken <= 5'(MAX_LENGTH)) begin
      status_d = ST_DECODED;
      length_d = nxt.bytes_taken;
      rel_d    = (nxt.opcode_class == K_REL8) || (nxt.opcode_class == K_REL32);
      rip_d    = nxt.rip_flag;
      dpos_d   = nxt.rip_flag ? nxt.disp_position : 4'd0;
      imm_d    = nxt.pending_immediate;
    end

    state_d = state_q;
    if (accept) state_d = emit ? dec_state_t'('0) : nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && emit) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      status_q <= status_d;
      length_q <= length_d;
      rel_q    <= rel_d;
      rip_q    <= rip_d;
      dpos_q   <= dpos_d;
      imm_q    <= imm_d;
    end
  end

  assign out_o.valid               = out_valid_q;
  assign out_o.status              = status_q;
  assign out_o.length              = length_q;
  assign out_o.relative_branch     = rel_q;
  assign out_o.rip_relative        = rip_q;
  assign out_o.displacement_offset = dpos_q;
  assign out_o.immediate_size      = imm_q;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// self-checking testbench for the byte-serial x86-64 instruction length decoder
// depends on xild_pkg, xild_in_if, xild_out_if and the decoder top level
// a local decoder model or a directed row predicts each measured instruction; results are checked in order
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import xild_pkg::*;

  localparam int MAX_LEN      = 16;
  localparam int RANDOM_BEATS = 1050;
  localparam int SEGMENT      = 130;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT      = 600;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 10;

  typedef enum logic [1:0] {
    FLOW_FREE        = 2'd0,
    FLOW_SEND_GAPS   = 2'd1,
    FLOW_RECV_STALLS = 2'd2,
    FLOW_BOTH        = 2'd3
  } traffic_e;

  typedef struct packed {
    status_e    status;
    logic [4:0] length;
    logic       relative_branch;
    logic       rip_relative;
    logic [3:0] displacement_offset;
    logic [3:0] immediate_size;
  } measure_t;

  typedef struct packed {
    phase_e     ph;
    logic [4:0] taken;
    logic       opsize16;
    logic       rex_w;
    op_class_e  kind;
    logic [1:0] mod_saved;
    logic [3:0] skip;
    logic [3:0] imm;
    logic       rip;
    logic [3:0] rip_at;
  } decoder_t;

  typedef struct packed {
    logic [7:0] code;
    logic       st;
    logic       typed;
    measure_t   want;
  } beat_t;

  typedef struct packed {
    logic [4:0]   n;
    logic [127:0] code;
    logic         st;
    logic         typed;
    measure_t     want;
  } vector_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  xild_in_if  byte_ch ();
  xild_out_if meas_ch ();

  x86_64_instruction_length_decoder #(.MAX_LENGTH(MAX_LEN)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .out_o  (meas_ch)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  beat_t    code_beats[$];
  vector_t  vectors[$];
  measure_t expected_lengths[$];
  decoder_t model;
  decoder_t gen_state;
  traffic_e traffic_mode = FLOW_FREE;
  logic     hold_go = 1'b0;
  int       mismatches = 0;
  int       quiet_cycles = 0;

  // opcode class tables

  function automatic logic in_span(input logic [7:0] b, input logic [7:0] lo,
                                   input logic [7:0] hi);
    return b >= lo && b <= hi;
  endfunction

  function automatic logic plain_prefix(input logic [7:0] b);
    return b == 8'h26 || b == 8'h2E || b == 8'h36 || b == 8'h3E || b == 8'h64 ||
           b == 8'h65 || b == 8'h67 || b == 8'hF0 || b == 8'hF2 || b == 8'hF3;
  endfunction

  function automatic op_class_e one_byte_kind(input logic [7:0] b);
    if (b < 8'h40) begin
      if (b == BYTE_ESCAPE) return K_INVALID;
      case (b[2:0])
        3'd0, 3'd1, 3'd2, 3'd3: return K_M;
        3'd4:                   return K_I8;
        3'd5:                   return K_IZ;
        default:                return K_INVALID;
      endcase
    end
    if (in_span(b, 8'h50, 8'h5F) || in_span(b, 8'h90, 8'h99)) return K_NONE;
    if (in_span(b, 8'h70, 8'h7F)) return K_REL8;
    if (in_span(b, 8'h84, 8'h8B) || in_span(b, 8'hD0, 8'hD3)) return K_M;
    if (in_span(b, 8'hB0, 8'hB7)) return K_I8;
    if (in_span(b, 8'hB8, 8'hBF)) return K_MOVI;
    case (b)
      8'h9C, 8'h9D, 8'hC3, 8'hC9, 8'hCC, 8'hF4: return K_NONE;
      8'hEB:                                    return K_REL8;
      8'hE8, 8'hE9:                             return K_REL32;
      8'h63, 8'h8D, 8'h8F, 8'hFE, 8'hFF:        return K_M;
      8'h6A, 8'hA8:                             return K_I8;
      8'h68, 8'hA9:                             return K_IZ;
      8'hC2:                                    return K_I16;
      8'h69, 8'h81, 8'hC7:                      return K_M_IZ;
      8'h6B, 8'h80, 8'h83, 8'hC0, 8'hC1, 8'hC6: return K_M_I8;
      8'hF6:                                    return K_GF6;
      8'hF7:                                    return K_GF7;
      default:                                  return K_INVALID;
    endcase
  endfunction

  function automatic op_class_e escaped_kind(input logic [7:0] b);
    case (b)
      8'h05, 8'h0B, 8'hA2:                      return K_NONE;
      8'hA4, 8'hAC, 8'hBA, 8'hC2:               return K_M_I8;
      8'hA3, 8'hA5, 8'hAB, 8'hAD, 8'hAE, 8'hAF,
      8'hB0, 8'hB1, 8'hC0, 8'hC1:               return K_M;
      default: ;
    endcase
    if (in_span(b, 8'h80, 8'h8F)) return K_REL32;
    if (in_span(b, 8'h70, 8'h73)) return K_M_I8;
    if (in_span(b, 8'h10, 8'h1F) || in_span(b, 8'h28, 8'h2F) || in_span(b, 8'h40, 8'h4F) ||
        in_span(b, 8'h51, 8'h6F) || in_span(b, 8'h74, 8'h7F) || in_span(b, 8'h90, 8'h9F) ||
        in_span(b, 8'hB3, 8'hB7) || in_span(b, 8'hBB, 8'hBF) || in_span(b, 8'hC3, 8'hC6) ||
        in_span(b, 8'hD0, 8'hFE))
      return K_M;
    return K_INVALID;
  endfunction

  // decoder model

  function automatic logic [3:0] imm_z(input decoder_t s);
    return s.opsize16 ? 4'd2 : 4'd4;
  endfunction

  function automatic outcome_e tail(inout decoder_t s, input logic [3:0] n);
    if (n == 4'd0) return OC_DONE;
    s.skip = n;
    s.ph = PH_SKIP;
    return OC_PENDING;
  endfunction

  function automatic outcome_e open_kind(inout decoder_t s, input op_class_e k);
    logic [3:0] imm;
    s.kind = k;
    imm = 4'd0;
    case (k)
      K_NONE: begin
        s.imm = 4'd0;
        return OC_DONE;
      end
      K_REL8: begin
        s.imm = 4'd0;
        return tail(s, 4'd1);
      end
      K_REL32: begin
        s.imm = 4'd0;
        return tail(s, 4'd4);
      end
      K_M, K_M_I8, K_M_IZ, K_GF6, K_GF7: begin
        s.ph = PH_MODRM;
        return OC_PENDING;
      end
      K_I8:    imm = 4'd1;
      K_I16:   imm = 4'd2;
      K_IZ:    imm = imm_z(s);
      K_MOVI:  imm = s.rex_w ? 4'd8 : imm_z(s);
      default: return OC_BAD;
    endcase
    s.imm = imm;
    return tail(s, imm);
  endfunction

  function automatic outcome_e take_modrm_byte(inout decoder_t s, input logic [7:0] b);
    logic [1:0] md;
    logic [2:0] rg;
    logic [2:0] rm;
    logic [3:0] imm;
    logic [3:0] disp;
    md = b[7:6];
    rg = b[5:3];
    rm = b[2:0];
    disp = 4'd0;
    case (s.kind)
      K_GF6:   imm = (rg <= 3'd1) ? 4'd1 : 4'd0;
      K_GF7:   imm = (rg <= 3'd1) ? imm_z(s) : 4'd0;
      K_M_I8:  imm = 4'd1;
      K_M_IZ:  imm = imm_z(s);
      default: imm = 4'd0;
    endcase
    s.imm = imm;
    if (md != MOD_REG && rm == RM_SIB) begin
      s.mod_saved = md;
      s.ph = PH_SIB;
      return OC_PENDING;
    end
    if (md == MOD_DISP8) disp = 4'd1;
    else if (md == MOD_DISP32) disp = 4'd4;
    else if (md == MOD_DISP0 && rm == RM_DISP32) begin
      s.rip = 1'b1;
      s.rip_at = s.taken[3:0];
      disp = 4'd4;
    end
    return tail(s, disp + imm);
  endfunction

  function automatic outcome_e take_sib_byte(inout decoder_t s, input logic [7:0] b);
    logic [3:0] disp;
    disp = 4'd0;
    if (s.mod_saved == MOD_DISP8) disp = 4'd1;
    else if (s.mod_saved == MOD_DISP32) disp = 4'd4;
    else if (s.mod_saved == MOD_DISP0 && b[2:0] == RM_DISP32) disp = 4'd4;
    return tail(s, disp + s.imm);
  endfunction

  // returns 1 when the byte ends an instruction, with its measurement in m
  function automatic logic decode_byte(inout decoder_t s, input logic [7:0] b,
                                       input logic st, output measure_t m);
    outcome_e oc;
    oc = OC_PENDING;
    m = '0;
    if (st) s = '0;
    s.taken = s.taken + 5'd1;
    case (s.ph)
      PH_OPCODE: begin
        if (b == BYTE_ESCAPE) s.ph = PH_ESCAPE;
        else oc = open_kind(s, one_byte_kind(b));
      end
      PH_ESCAPE: begin
        if (b == BYTE_MAP38 || b == BYTE_MAP3A) begin
          s.kind = (b == BYTE_MAP3A) ? K_M_I8 : K_M;
          s.ph = PH_MAP3;
        end else begin
          oc = open_kind(s, escaped_kind(b));
        end
      end
      PH_MAP3:  s.ph = PH_MODRM;
      PH_MODRM: oc = take_modrm_byte(s, b);
      PH_SIB:   oc = take_sib_byte(s, b);
      PH_SKIP: begin
        s.skip = s.skip - 4'd1;
        if (s.skip == 4'd0) oc = OC_DONE;
      end
      default: begin
        if (b == BYTE_OPSIZE) s.opsize16 = 1'b1;
        else if ((b & REX_MASK) == REX_BASE) begin
          s.rex_w = (b & REX_W_BIT) != 8'h00;
          s.ph = PH_OPCODE;
        end else if (b == BYTE_ESCAPE) s.ph = PH_ESCAPE;
        else if (!plain_prefix(b)) oc = open_kind(s, one_byte_kind(b));
      end
    endcase
    if (oc == OC_PENDING && s.taken < MAX_LEN) return 1'b0;
    if (oc == OC_BAD) begin
      m.status = ST_INVALID;
    end else if (oc == OC_DONE && s.taken <= MAX_LEN) begin
      m.status = ST_DECODED;
      m.length = s.taken;
      m.relative_branch = s.kind == K_REL8 || s.kind == K_REL32;
      m.rip_relative = s.rip;
      m.displacement_offset = s.rip ? s.rip_at : 4'd0;
      m.immediate_size = s.imm;
    end else begin
      m.status = ST_TOO_LONG;
    end
    s = '0;
    return 1'b1;
  endfunction

  // stimulus

  function automatic measure_t meas(input status_e st, input logic [4:0] len,
                                    input logic br, input logic rip,
                                    input logic [3:0] off, input logic [3:0] imm);
    measure_t m;
    m.status = st;
    m.length = len;
    m.relative_branch = br;
    m.rip_relative = rip;
    m.displacement_offset = off;
    m.immediate_size = imm;
    return m;
  endfunction

  task automatic add_row(input logic [4:0] n, input logic [127:0] code, input logic st,
                         input logic typed, input measure_t want);
    vector_t v;
    v.n = n;
    v.code = code;
    v.st = st;
    v.typed = typed;
    v.want = want;
    vectors.push_back(v);
  endtask

  task automatic push_beat(inout decoder_t s, input logic [7:0] b, inout logic st,
                           input logic typed, input measure_t want, output logic done);
    beat_t bt;
    measure_t m;
    bt.code = b;
    bt.st = st;
    bt.typed = typed;
    bt.want = want;
    code_beats.push_back(bt);
    done = decode_byte(s, b, st, m);
    st = 1'b0;
  endtask

  function automatic logic [7:0] any_prefix();
    case ($urandom_range(0, 10))
      0:       return BYTE_OPSIZE;
      1:       return 8'h67;
      2:       return 8'hF0;
      3:       return 8'hF2;
      4:       return 8'hF3;
      5:       return 8'h2E;
      6:       return 8'h36;
      7:       return 8'h3E;
      8:       return 8'h26;
      9:       return 8'h64;
      default: return 8'h65;
    endcase
  endfunction

  // one instruction with random content; a few are cut short and the next one restarts
  task automatic add_instruction(inout decoder_t s, inout logic st);
    logic       done;
    logic       broken;
    logic       bad_op;
    logic [7:0] b;
    int         pre;
    int         tail_cap;
    int         tail_n;
    done = 1'b0;
    if ($urandom_range(0, 9) == 0) st = 1'b1;
    broken = $urandom_range(0, 11) == 0;
    pre = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 16) : $urandom_range(0, 2);
    bad_op = pre >= 13 && $urandom_range(0, 1) == 1;
    for (int k = 0; k < pre && !done; k++) push_beat(s, any_prefix(), st, 1'b0, '0, done);
    if (!done && $urandom_range(0, 9) < 3) begin
      b = 8'($urandom_range(0, 15));
      push_beat(s, b | REX_BASE, st, 1'b0, '0, done);
    end
    if (!done) begin
      if (bad_op) begin
        b = 8'($urandom_range(0, 255));
        while (one_byte_kind(b) != K_INVALID || b == BYTE_OPSIZE || b == BYTE_ESCAPE ||
               plain_prefix(b) || (b & REX_MASK) == REX_BASE)
          b = 8'($urandom_range(0, 255));
        push_beat(s, b, st, 1'b0, '0, done);
      end else begin
        case ($urandom_range(0, 9))
          6, 7, 8: begin
            push_beat(s, BYTE_ESCAPE, st, 1'b0, '0, done);
            b = 8'($urandom_range(0, 255));
            while (escaped_kind(b) == K_INVALID) b = 8'($urandom_range(0, 255));
            if (!done) push_beat(s, b, st, 1'b0, '0, done);
          end
          9: begin
            push_beat(s, BYTE_ESCAPE, st, 1'b0, '0, done);
            b = $urandom_range(0, 1) ? BYTE_MAP3A : BYTE_MAP38;
            if (!done) push_beat(s, b, st, 1'b0, '0, done);
            b = 8'($urandom_range(0, 255));
            if (!done) push_beat(s, b, st, 1'b0, '0, done);
          end
          default: begin
            b = 8'($urandom_range(0, 255));
            while (one_byte_kind(b) == K_INVALID) b = 8'($urandom_range(0, 255));
            push_beat(s, b, st, 1'b0, '0, done);
          end
        endcase
      end
    end
    tail_cap = broken ? $urandom_range(0, 3) : 64;
    tail_n = 0;
    while (!done && tail_n < tail_cap) begin
      b = 8'($urandom_range(0, 255));
      if (s.ph == PH_MODRM) begin
        case ($urandom_range(0, 3))
          0: begin
            b[7:6] = MOD_DISP0;
            b[2:0] = RM_DISP32;
          end
          1: begin
            b[7:6] = 2'($urandom_range(0, 2));
            b[2:0] = RM_SIB;
          end
          default: ;
        endcase
      end
      push_beat(s, b, st, 1'b0, '0, done);
      tail_n++;
    end
    if (!done) st = 1'b1;
  endtask

  // traffic shaping

  function automatic logic sender_gap(input traffic_e mode);
    case (mode)
      FLOW_SEND_GAPS: return $urandom_range(0, 99) < 69;
      FLOW_BOTH:      return $urandom_range(0, 99) < 18;
      default:        return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_stall(input traffic_e mode);
    case (mode)
      FLOW_RECV_STALLS: return $urandom_range(0, 99) < 69;
      FLOW_BOTH:        return $urandom_range(0, 99) < 18;
      default:          return 1'b0;
    endcase
  endfunction

  initial begin
    int  hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    meas_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        meas_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_go && !hold_done) begin
        meas_ch.ready <= 1'b0;
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        meas_ch.ready <= !receiver_stall(traffic_mode);
      end
    end
  end

  // result checking

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    measure_t want;
    if (meas_ch.valid === 1'b1 && meas_ch.ready === 1'b1) begin
      if (expected_lengths.size() == 0) begin
        $error("result beat with no instruction pending: status %0d length %0d",
               meas_ch.status, meas_ch.length);
        mismatches++;
      end else begin
        want = expected_lengths.pop_front();
        check_field("status", 8'(want.status), 8'(meas_ch.status));
        check_field("length", 8'(want.length), 8'(meas_ch.length));
        check_field("relative_branch", 8'(want.relative_branch), 8'(meas_ch.relative_branch));
        check_field("rip_relative", 8'(want.rip_relative), 8'(meas_ch.rip_relative));
        check_field("displacement_offset", 8'(want.displacement_offset),
                    8'(meas_ch.displacement_offset));
        check_field("immediate_size", 8'(want.immediate_size), 8'(meas_ch.immediate_size));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((byte_ch.valid && byte_ch.ready) || (meas_ch.valid && meas_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    vector_t  v;
    beat_t    item;
    measure_t got_m;
    logic     st;
    logic     done;
    logic [7:0] b;
    int       first_random;

    byte_ch.valid <= 1'b0;
    byte_ch.code_byte <= 8'h00;
    byte_ch.start_req <= 1'b0;
    model = '0;
    gen_state = '0;

    // directed: first byte after reset, restart, prefixes, invalid opcodes, several classes
    add_row(5'd1, 128'h90, 1'b0, 1'b1, meas(ST_DECODED, 5'd1, 1'b0, 1'b0, 4'd0, 4'd0));
    add_row(5'd1, 128'h48, 1'b0, 1'b0, '0);
    add_row(5'd1, 128'h90, 1'b1, 1'b1, meas(ST_DECODED, 5'd1, 1'b0, 1'b0, 4'd0, 4'd0));
    add_row(5'd4, 128'h66B83412, 1'b0, 1'b1,
            meas(ST_DECODED, 5'd4, 1'b0, 1'b0, 4'd0, 4'd2));
    add_row(5'd2, 128'h4166, 1'b0, 1'b1, meas(ST_INVALID, 5'd0, 1'b0, 1'b0, 4'd0, 4'd0));
    add_row(5'd1, 128'h06, 1'b0, 1'b1, meas(ST_INVALID, 5'd0, 1'b0, 1'b0, 4'd0, 4'd0));
    add_row(5'd2, 128'h0F0B, 1'b0, 1'b0, '0);
    add_row(5'd6, 128'hF7C078563412, 1'b0, 1'b0, '0);
    add_row(5'd2, 128'hEBFE, 1'b0, 1'b0, '0);
    add_row(5'd6, 128'h8B0578563412, 1'b0, 1'b0, '0);
    add_row(5'd5, 128'h0F3A0FC108, 1'b0, 1'b0, '0);
    add_row(5'd2, 128'h00C0, 1'b0, 1'b0, '0);
    add_row(5'd2, 128'hFFE0, 1'b0, 1'b0, '0);

    foreach (vectors[r]) begin
      v = vectors[r];
      st = v.st;
      for (int i = 0; i < v.n; i++)
        push_beat(gen_state, v.code[8 * (v.n - 1 - i) +: 8], st, v.typed, v.want, done);
    end
    first_random = code_beats.size();

    st = 1'b0;
    while (code_beats.size() < first_random + RANDOM_BEATS) begin
      if ($urandom_range(0, 99) < 14) begin
        if ($urandom_range(0, 4) == 0) st = 1'b1;
        b = 8'($urandom_range(0, 255));
        push_beat(gen_state, b, st, 1'b0, '0, done);
      end else begin
        add_instruction(gen_state, st);
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < code_beats.size(); i++) begin
      item = code_beats[i];
      if (i >= first_random) traffic_mode <= traffic_e'(((i - first_random) / SEGMENT) % 4);
      if (i == first_random + HOLD_AT) hold_go <= 1'b1;
      while (sender_gap(traffic_mode)) begin
        byte_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
      byte_ch.valid <= 1'b1;
      byte_ch.code_byte <= item.code;
      byte_ch.start_req <= item.st;
      @(posedge clk_i);
      while (!byte_ch.ready) @(posedge clk_i);
      if (decode_byte(model, item.code, item.st, got_m))
        expected_lengths.push_back(item.typed ? item.want : got_m);
    end
    byte_ch.valid <= 1'b0;
    traffic_mode <= FLOW_FREE;

    while (expected_lengths.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
